// ===== design/rtc_pkg.sv =====
// Shared types and constants for the RGBA to text cell classifier.
package rtc_pkg;

  // One primary/secondary pair: channel indexes and the colors it selects
  typedef struct packed {
    logic [1:0] pri_idx;
    logic [1:0] sec_idx;
    logic [3:0] fg_bright;
    logic [3:0] fg_dark;
    logic [3:0] bg_bright;
    logic [3:0] bg_dark;
  } pair_t;

  localparam int NUM_PAIRS = 9;

  // Pairs in decision order; the last matching one wins
  localparam pair_t PAIRS [NUM_PAIRS] = '{
    '{2'd0, 2'd0, 4'd12, 4'd4, 4'd14, 4'd6},
    '{2'd0, 2'd2, 4'd12, 4'd4, 4'd13, 4'd5},
    '{2'd0, 2'd1, 4'd12, 4'd4, 4'd11, 4'd3},
    '{2'd1, 2'd0, 4'd10, 4'd2, 4'd14, 4'd6},
    '{2'd1, 2'd1, 4'd10, 4'd2, 4'd11, 4'd3},
    '{2'd1, 2'd2, 4'd10, 4'd2, 4'd13, 4'd5},
    '{2'd2, 2'd2, 4'd9,  4'd1, 4'd13, 4'd5},
    '{2'd2, 2'd1, 4'd9,  4'd1, 4'd11, 4'd3},
    '{2'd2, 2'd0, 4'd9,  4'd1, 4'd14, 4'd6}
  };

  // Grey background codes
  localparam logic [3:0] COL_BLACK     = 4'd0;
  localparam logic [3:0] COL_DARK_GREY = 4'd8;
  localparam logic [3:0] COL_GREY      = 4'd7;
  localparam logic [3:0] COL_WHITE     = 4'd15;

  // Glyph codes
  localparam logic [2:0] GLYPH_SPACE   = 3'd0;
  localparam logic [2:0] GLYPH_QUARTER = 3'd1;
  localparam logic [2:0] GLYPH_HALF    = 3'd2;
  localparam logic [2:0] GLYPH_THREE_Q = 3'd3;
  localparam logic [2:0] GLYPH_SOLID   = 3'd4;

  // Shade thresholds on d = c1 - c2 + 255
  localparam logic [9:0] SHADE_T1 = 10'd102;
  localparam logic [9:0] SHADE_T2 = 10'd204;
  localparam logic [9:0] SHADE_T3 = 10'd306;
  localparam logic [9:0] SHADE_T4 = 10'd408;

  // Secondary deviation at or below this counts as grey
  localparam logic [8:0] GREY_DEV_MAX = 9'd7;

  // Brightness thresholds
  localparam logic [7:0] LIGHT_MIN  = 8'd128;
  localparam logic [7:0] GREY_T1    = 8'd64;
  localparam logic [7:0] GREY_T2    = 8'd128;
  localparam logic [7:0] GREY_T3    = 8'd192;
  localparam logic [7:0] OPAQUE_VAL = 8'd255;

endpackage

// ===== design/rgb_to_text_cell_classifier_top.sv =====
// Throughput: one pixel per cycle while out_stall is low. Three register stages:
// minima and sums, absolute deviations, pair selection into the output register.
// Each stage advances when the next one is empty or moving, so bubbles close up.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module rgb_to_text_cell_classifier_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_attribute,
  output logic [2:0] out_glyph
);
  import rtc_pkg::*;

  // Stage valid bits and readiness
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_ready, s2_ready, s1_ready;

  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign out_valid = out_v_r;

  // Stage 1 registers: channels, pairwise minima, sums
  logic [7:0] s1_p_r [3];
  logic [7:0] s1_s_r [3];
  logic [9:0] s1_sum_r, s1_sum2_r;
  logic       s1_opq_r;

  logic [7:0] p_in [3];
  logic [7:0] s_in [3];

  always_comb begin
    p_in[0] = in_red;
    p_in[1] = in_green;
    p_in[2] = in_blue;
    s_in[0] = (in_red   < in_green) ? in_red   : in_green;
    s_in[1] = (in_green < in_blue)  ? in_green : in_blue;
    s_in[2] = (in_blue  < in_red)   ? in_blue  : in_red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_p_r    <= p_in;
      s1_s_r    <= s_in;
      s1_sum_r  <= {2'b00, p_in[0]} + {2'b00, p_in[1]} + {2'b00, p_in[2]};
      s1_sum2_r <= {2'b00, s_in[0]} + {2'b00, s_in[1]} + {2'b00, s_in[2]};
      s1_opq_r  <= (in_alpha == OPAQUE_VAL);
    end
  end

  // Stage 2: absolute deviations 3*x - sum, range 0..510
  logic [7:0]  s2_p_r [3];
  logic [7:0]  s2_s_r [3];
  logic [8:0]  s2_pd_r [3];
  logic [8:0]  s2_sd_r [3];
  logic        s2_opq_r;
  logic [8:0]  pd_nxt [3];
  logic [8:0]  sd_nxt [3];
  logic [10:0] pdev, sdev;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pdev = {3'b000, s1_p_r[k]} + {2'b00, s1_p_r[k], 1'b0} - {1'b0, s1_sum_r};
      sdev = {3'b000, s1_s_r[k]} + {2'b00, s1_s_r[k], 1'b0} - {1'b0, s1_sum2_r};
      pd_nxt[k] = pdev[10] ? 9'(-pdev) : pdev[8:0];
      sd_nxt[k] = sdev[10] ? 9'(-sdev) : sdev[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_ready && s1_v_r) begin
      s2_p_r   <= s1_p_r;
      s2_s_r   <= s1_s_r;
      s2_pd_r  <= pd_nxt;
      s2_sd_r  <= sd_nxt;
      s2_opq_r <= s1_opq_r;
    end
  end

  // Stage 3: maxima, last matching pair, colors and shade
  logic [8:0] pmax, smax;
  logic [7:0] c1, c2;
  logic [1:0] pi, si;
  logic [3:0] fg, bg;
  logic [9:0] shade;
  logic [7:0] attr_nxt;
  logic [2:0] glyph_nxt;
  logic [7:0] out_attr_r;
  logic [2:0] out_glyph_r;

  always_comb begin
    pmax = 9'd0;
    smax = 9'd0;
    for (int k = 0; k < 3; k++) begin
      if (s2_pd_r[k] > pmax) pmax = s2_pd_r[k];
      if (s2_sd_r[k] > smax) smax = s2_sd_r[k];
    end
    attr_nxt  = 8'd0;
    glyph_nxt = GLYPH_SPACE;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      pi = PAIRS[k].pri_idx;
      si = PAIRS[k].sec_idx;
      c1 = s2_p_r[pi];
      c2 = s2_s_r[si];
      fg = (c1 >= LIGHT_MIN) ? PAIRS[k].fg_bright : PAIRS[k].fg_dark;
      if (s2_sd_r[si] <= GREY_DEV_MAX) begin
        if (c2 < GREY_T1)      bg = COL_BLACK;
        else if (c2 < GREY_T2) bg = COL_DARK_GREY;
        else if (c2 < GREY_T3) bg = COL_GREY;
        else                   bg = COL_WHITE;
      end else begin
        bg = (c2 >= LIGHT_MIN) ? PAIRS[k].bg_bright : PAIRS[k].bg_dark;
      end
      shade = {2'b00, c1} + 10'd255 - {2'b00, c2};
      if (s2_pd_r[pi] == pmax && s2_sd_r[si] == smax && s2_opq_r) begin
        attr_nxt = {bg, fg};
        if (shade < SHADE_T1)      glyph_nxt = GLYPH_SPACE;
        else if (shade < SHADE_T2) glyph_nxt = GLYPH_QUARTER;
        else if (shade < SHADE_T3) glyph_nxt = GLYPH_HALF;
        else if (shade < SHADE_T4) glyph_nxt = GLYPH_THREE_Q;
        else                       glyph_nxt = GLYPH_SOLID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= s2_v_r;
    end
    if (out_ready && s2_v_r) begin
      out_attr_r  <= attr_nxt;
      out_glyph_r <= glyph_nxt;
    end
  end

  assign out_attribute = out_attr_r;
  assign out_glyph     = out_glyph_r;

  // Input backpressure only when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_v_r))
    else $error("input stalled with an empty stage");

  // An accepted word lands in stage 1
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_v_r)
    else $error("accepted word lost at stage 1");

  // A stalled stage 2 word is held for the output register
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_ready) |=> (s2_v_r && $stable(s2_pd_r[0]) && $stable(s2_sd_r[0])))
    else $error("stage 2 word changed while stalled");

  // Glyph code stays within the five shades
  a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_glyph_r <= GLYPH_SOLID))
    else $error("glyph code out of range");

  // Pixels that are not fully opaque produce a blank cell
  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_opq_r && out_ready) |=> (out_attr_r == 8'd0 && out_glyph_r == GLYPH_SPACE))
    else $error("transparent pixel gave a non-blank cell");

endmodule

// ===== dv/tb.sv =====
// Testbench for the RGBA to text cell classifier: stimulus, cell prediction and checks.
`timescale 1ns / 1ps

module tb;
  import rtc_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_PIXELS = 850;

  // Console color codes
  typedef enum logic [3:0] {
    CON_BLACK, CON_DK_BLUE, CON_DK_GREEN, CON_DK_CYAN, CON_DK_RED, CON_DK_MAGENTA,
    CON_DK_YELLOW, CON_GREY, CON_DK_GREY, CON_BLUE, CON_GREEN, CON_CYAN, CON_RED,
    CON_MAGENTA, CON_YELLOW, CON_WHITE
  } console_color_t;

  // Primary channels and secondary (pairwise minimum) channels
  typedef enum int {CH_RED = 0, CH_GREEN = 1, CH_BLUE = 2} channel_t;
  typedef enum int {MIN_RG = 0, MIN_GB = 1, MIN_BR = 2} minimum_t;

  typedef struct {
    channel_t       pri;
    minimum_t       sec;
    console_color_t fg_lt;
    console_color_t fg_dk;
    console_color_t bg_lt;
    console_color_t bg_dk;
  } color_pair_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [2:0] glyph;
  } cell_t;

  class cell_scoreboard;
    cell_t expected_cells[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    // Pairs in decision order; the last one that matches wins
    function color_pair_t color_pair(int k);
      color_pair_t cp;
      case (k)
        0: cp = '{CH_RED,   MIN_RG, CON_RED,   CON_DK_RED,   CON_YELLOW,  CON_DK_YELLOW};
        1: cp = '{CH_RED,   MIN_BR, CON_RED,   CON_DK_RED,   CON_MAGENTA, CON_DK_MAGENTA};
        2: cp = '{CH_RED,   MIN_GB, CON_RED,   CON_DK_RED,   CON_CYAN,    CON_DK_CYAN};
        3: cp = '{CH_GREEN, MIN_RG, CON_GREEN, CON_DK_GREEN, CON_YELLOW,  CON_DK_YELLOW};
        4: cp = '{CH_GREEN, MIN_GB, CON_GREEN, CON_DK_GREEN, CON_CYAN,    CON_DK_CYAN};
        5: cp = '{CH_GREEN, MIN_BR, CON_GREEN, CON_DK_GREEN, CON_MAGENTA, CON_DK_MAGENTA};
        6: cp = '{CH_BLUE,  MIN_BR, CON_BLUE,  CON_DK_BLUE,  CON_MAGENTA, CON_DK_MAGENTA};
        7: cp = '{CH_BLUE,  MIN_GB, CON_BLUE,  CON_DK_BLUE,  CON_CYAN,    CON_DK_CYAN};
        default: cp = '{CH_BLUE, MIN_RG, CON_BLUE, CON_DK_BLUE, CON_YELLOW, CON_DK_YELLOW};
      endcase
      return cp;
    endfunction

    // Compute the text cell for one pixel with exact integer deviations
    function cell_t classify(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      int pv[3], sv[3], pd[3], sd[3];
      int psum, ssum, pmax, smax, c1, c2, shade;
      color_pair_t cp;
      console_color_t fg, bg;
      cell_t res;
      res.attr  = 8'd0;
      res.glyph = GLYPH_SPACE;
      if (a != OPAQUE_VAL) return res;
      pv[CH_RED]   = int'(r);
      pv[CH_GREEN] = int'(g);
      pv[CH_BLUE]  = int'(b);
      sv[MIN_RG] = int'((r < g) ? r : g);
      sv[MIN_GB] = int'((g < b) ? g : b);
      sv[MIN_BR] = int'((b < r) ? b : r);
      psum = pv[0] + pv[1] + pv[2];
      ssum = sv[0] + sv[1] + sv[2];
      pmax = 0;
      smax = 0;
      for (int i = 0; i < 3; i++) begin
        pd[i] = 3 * pv[i] - psum;
        sd[i] = 3 * sv[i] - ssum;
        if (pd[i] < 0) pd[i] = -pd[i];
        if (sd[i] < 0) sd[i] = -sd[i];
        if (pd[i] > pmax) pmax = pd[i];
        if (sd[i] > smax) smax = sd[i];
      end
      for (int k = 0; k < 9; k++) begin
        cp = color_pair(k);
        if (pd[cp.pri] != pmax || sd[cp.sec] != smax) continue;
        c1 = pv[cp.pri];
        c2 = sv[cp.sec];
        fg = (c1 >= 128) ? cp.fg_lt : cp.fg_dk;
        // Near-flat secondaries give a grey background by brightness
        if (sd[cp.sec] <= 7) begin
          if (c2 < 64) bg = CON_BLACK;
          else if (c2 < 128) bg = CON_DK_GREY;
          else if (c2 < 192) bg = CON_GREY;
          else bg = CON_WHITE;
        end else begin
          bg = (c2 >= 128) ? cp.bg_lt : cp.bg_dk;
        end
        shade = c1 + 255 - c2;
        if (shade < 102) res.glyph = GLYPH_SPACE;
        else if (shade < 204) res.glyph = GLYPH_QUARTER;
        else if (shade < 306) res.glyph = GLYPH_HALF;
        else if (shade < 408) res.glyph = GLYPH_THREE_Q;
        else res.glyph = GLYPH_SOLID;
        res.attr = {bg, fg};
      end
      return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      expected_cells.push_back(classify(r, g, b, a));
    endfunction

    function void check_cell(logic [7:0] attr, logic [2:0] glyph);
      cell_t want;
      if (expected_cells.size() == 0) begin
        $error("result word with none expected: attribute %0d glyph %0d", attr, glyph);
        errors++;
        return;
      end
      want = expected_cells.pop_front();
      if (attr !== want.attr) begin
        $error("attribute: expected 0x%02h, actual 0x%02h", want.attr, attr);
        errors++;
      end
      if (glyph !== want.glyph) begin
        $error("glyph: expected %0d, actual %0d", want.glyph, glyph);
        errors++;
      end
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_attribute;
  logic [2:0] out_glyph;

  cell_scoreboard sb = new();
  bit steady;
  int cycle_count = 0;

  rgb_to_text_cell_classifier_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_attribute (out_attribute),
    .out_glyph     (out_glyph)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one pixel word and hold it until accepted
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_alpha <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(r, g, b, a);
  endtask

  // Random pixel of one of several shapes: uniform, near grey, ties, levels, dominant, grey
  task automatic send_random_pixel();
    logic [7:0] ch[3];
    logic [7:0] a;
    logic [7:0] levels[8];
    int base;
    logic [1:0] k;
    levels = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
    k = 2'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        foreach (ch[i]) ch[i] = 8'($urandom_range(0, 255));
      end
      4, 5: begin
        base = $urandom_range(0, 250);
        foreach (ch[i]) ch[i] = 8'(base + $urandom_range(0, 5));
      end
      6: begin
        ch[0] = 8'($urandom_range(0, 255));
        ch[1] = ch[0];
        ch[2] = ch[0];
        ch[k] = 8'($urandom_range(0, 255));
      end
      7: begin
        foreach (ch[i]) ch[i] = levels[3'($urandom_range(0, 7))];
      end
      8: begin
        foreach (ch[i]) ch[i] = 8'($urandom_range(0, 60));
        ch[k] = 8'($urandom_range(200, 255));
      end
      default: begin
        ch[0] = 8'($urandom_range(0, 255));
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
    endcase
    if ($urandom_range(0, 99) < 85) a = 8'hFF;
    else if ($urandom_range(0, 1) == 1) a = 8'hFE;
    else a = 8'($urandom_range(0, 254));
    send_pixel(ch[0], ch[1], ch[2], a);
  endtask

  // Result side: free stretches and stalls of random length
  initial begin : stall_gen
    int free, hold;
    out_stall <= 1'b0;
    forever begin
      free = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      out_stall <= 1'b0;
      repeat (free) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Check each accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_cell(out_attribute, out_glyph);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** rgb_to_text_cell_classifier_top: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    steady   = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_red   <= 8'd0;
    in_green <= 8'd0;
    in_blue  <= 8'd0;
    in_alpha <= 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Black, white and transparent pixels
    send_pixel(8'd0, 8'd0, 8'd0, 8'hFF);
    send_pixel(8'd255, 8'd255, 8'd255, 8'hFF);
    send_pixel(8'd255, 8'd255, 8'd255, 8'hFE);
    send_pixel(8'd255, 8'd0, 8'd0, 8'h00);
    send_pixel(8'd128, 8'd128, 8'd128, 8'h7F);
    // Pure primaries and secondaries
    send_pixel(8'd255, 8'd0, 8'd0, 8'hFF);
    send_pixel(8'd0, 8'd255, 8'd0, 8'hFF);
    send_pixel(8'd0, 8'd0, 8'd255, 8'hFF);
    send_pixel(8'd255, 8'd255, 8'd0, 8'hFF);
    send_pixel(8'd0, 8'd255, 8'd255, 8'hFF);
    send_pixel(8'd255, 8'd0, 8'd255, 8'hFF);
    // Dark versus light foreground
    send_pixel(8'd127, 8'd0, 8'd0, 8'hFF);
    send_pixel(8'd128, 8'd0, 8'd0, 8'hFF);
    // Grey background brightness bands
    send_pixel(8'd63, 8'd63, 8'd63, 8'hFF);
    send_pixel(8'd64, 8'd64, 8'd64, 8'hFF);
    send_pixel(8'd127, 8'd127, 8'd127, 8'hFF);
    send_pixel(8'd128, 8'd128, 8'd128, 8'hFF);
    send_pixel(8'd191, 8'd191, 8'd191, 8'hFF);
    send_pixel(8'd192, 8'd192, 8'd192, 8'hFF);
    // Secondary deviation just inside and just outside the grey band
    send_pixel(8'd200, 8'd200, 8'd197, 8'hFF);
    send_pixel(8'd200, 8'd200, 8'd196, 8'hFF);
    // Shade edge between space and quarter
    send_pixel(8'd0, 8'd154, 8'd154, 8'hFF);
    send_pixel(8'd0, 8'd153, 8'd153, 8'hFF);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      send_random_pixel();
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** rgb_to_text_cell_classifier_top: PASSED **");
    end else begin
      $display("** rgb_to_text_cell_classifier_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== rgb_to_text_cell_classifier_top.f =====
design/rtc_pkg.sv
design/rgb_to_text_cell_classifier_top.sv
dv/tb.sv
